>>> hw/rtl/vna_pkg.sv
// Shared types and constants of the vertex normal averager.
// Used by the store, the shared multiplier and the top level; depends on nothing.
package vna_pkg;

   localparam int VERTEX_COUNT = 256;
   localparam int IDX_W        = 8;
   localparam int POS_W        = 16;
   localparam int SUM_W        = 24;
   localparam int NRM_W        = 16;
   localparam int MUL_W        = 31;
   localparam int PROD_W       = 2 * MUL_W;

   // Request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_TRI  = 2'd1,
      REQ_READ = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   // Sequencer states
   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_FETCH = 12'b0000_0000_0010,
      ST_EDGE  = 12'b0000_0000_0100,
      ST_CROSS = 12'b0000_0000_1000,
      ST_SREAD = 12'b0000_0001_0000,
      ST_ABS   = 12'b0000_0010_0000,
      ST_SHIFT = 12'b0000_0100_0000,
      ST_SQ    = 12'b0000_1000_0000,
      ST_SQRT  = 12'b0001_0000_0000,
      ST_DIV   = 12'b0010_0000_0000,
      ST_ACC   = 12'b0100_0000_0000,
      ST_OUT   = 12'b1000_0000_0000
   } state_type;

   // Accesses to the position and normal sum stores
   typedef struct packed {
      logic                   pos_we;
      logic [IDX_W-1:0]       pos_waddr;
      logic [3*POS_W-1:0]     pos_wdata;
      logic                   pos_re;
      logic [IDX_W-1:0]       pos_raddr;
      logic                   sum_re;
      logic [IDX_W-1:0]       sum_raddr;
      logic                   sum_we;
      logic [IDX_W-1:0]       sum_waddr;
      logic [3*SUM_W-1:0]     sum_wdata;
      logic                   sum_clr;
      logic [IDX_W-1:0]       sum_caddr;
   } store_ctrl_type;

endpackage

>>> hw/rtl/vertex_normal_averager.sv
// Top level of the vertex normal averager: sequencer and datapath around one
// shared multiplier. Depends on vna_pkg, vna_mult and vna_store.
//
// A load item stores a Q8.8 position while clearing that vertex's normal sum.
// A triangle item reads its three positions, forms the edge cross product with
// six passes through the shared multiplier, normalizes it and adds the Q1.14
// unit vector to the three vertex sums; a zero cross product adds nothing. A
// read item normalizes the stored sum and returns one result item. The time
// taken is set by the one-bit-a-cycle scaling shift, the square root and the
// three divisions that share one sequencer. The block is not ready while an
// item is being worked on; a finished result waits in an output register.
module vertex_normal_averager (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vertex_index[7:0], pos_x[23:8], pos_y[39:24], pos_z[55:40],
   // tri_a[63:56], tri_b[71:64], tri_c[79:72]
   input  logic [79:0]  req_tdata,
   // req_type[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
   output logic [47:0]  rsp_tdata,
   // zero_normal[0]
   output logic [0:0]   rsp_tuser
);

   localparam int CW = 36;   // cross product / sum width
   localparam int MW = 35;   // magnitude width
   localparam int SW = 62;   // square sum width

   vna_pkg::state_type      state_ff, state_in;
   vna_pkg::store_ctrl_type st_ctrl;
   logic [5:0]              cnt_ff, cnt_in;
   logic [1:0]              comp_ff, comp_in;
   logic                    is_tri_ff, is_tri_in;
   logic [7:0]              idx_ff [3];
   logic [7:0]              idx_in [3];
   logic [47:0]             p_ff [3];
   logic [47:0]             p_in [3];
   logic signed [16:0]      e1_ff [3];
   logic signed [16:0]      e1_in [3];
   logic signed [16:0]      e2_ff [3];
   logic signed [16:0]      e2_in [3];
   logic signed [CW-1:0]    c_ff [3];
   logic signed [CW-1:0]    c_in [3];
   logic [MW-1:0]           m_ff [3];
   logic [MW-1:0]           m_in [3];
   logic                    neg_ff [3];
   logic                    neg_in [3];
   logic signed [15:0]      n_ff [3];
   logic signed [15:0]      n_in [3];
   logic [SW-1:0]           s_ff, s_in;
   logic [SW-1:0]           x_ff, x_in;
   logic [SW-1:0]           res_ff, res_in;
   logic [SW-1:0]           bit_ff, bit_in;
   logic [32:0]             rem_ff, rem_in;
   logic [14:0]             lo_ff, lo_in;
   logic [14:0]             q_ff, q_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [47:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_zero_ff, rsp_zero_in;

   logic signed [vna_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [vna_pkg::PROD_W-1:0] prod;
   logic [47:0]             pos_rdata;
   logic [71:0]             sum_rdata;

   logic                    accept;
   logic [2:0]              step;
   logic [1:0]              pick;
   logic [SW-1:0]           t_sq;
   logic [30:0]             len;
   logic [32:0]             div_d, r2;
   logic [14:0]             q_new;
   logic signed [23:0]      sum_old, sum_new;
   logic                    any_hi, all_lo;

   function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                  input logic signed [15:0] b);
      logic signed [24:0] r;
      r = {a[23], a} + {{9{b[15]}}, b};
      if (r[24] != r[23]) begin
         return r[24] ? 24'sh800000 : 24'sh7fffff;
      end
      return r[23:0];
   endfunction

   function automatic logic signed [30:0] ext17(input logic signed [16:0] v);
      return {{14{v[16]}}, v};
   endfunction

   vna_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   vna_store u_store (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (st_ctrl),
      .pos_rdata (pos_rdata),
      .sum_rdata (sum_rdata)
   );

   assign req_tready = (state_ff == vna_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      is_tri_in    = is_tri_ff;
      s_in         = s_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      q_in         = q_ff;
      zero_in      = zero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int i = 0; i < 3; i++) begin
         idx_in[i] = idx_ff[i];
         p_in[i]   = p_ff[i];
         e1_in[i]  = e1_ff[i];
         e2_in[i]  = e2_ff[i];
         c_in[i]   = c_ff[i];
         m_in[i]   = m_ff[i];
         neg_in[i] = neg_ff[i];
         n_in[i]   = n_ff[i];
      end
      st_ctrl = '0;
      mul_a   = '0;
      mul_b   = '0;
      step    = cnt_ff[2:0] - 3'd1;
      pick    = cnt_ff[1:0];
      t_sq    = res_ff + bit_ff;
      len     = res_ff[30:0];
      div_d   = {1'b0, len, 1'b0};
      r2      = {rem_ff[31:0], lo_ff[14]};
      q_new   = {q_ff[13:0], (r2 >= div_d)};
      sum_old = '0;
      sum_new = '0;
      any_hi  = (m_ff[0][34:30] != '0) || (m_ff[1][34:30] != '0) ||
                (m_ff[2][34:30] != '0);
      all_lo  = (m_ff[0][34:29] == '0) && (m_ff[1][34:29] == '0) &&
                (m_ff[2][34:29] == '0);

      unique case (state_ff)
         vna_pkg::ST_IDLE: begin
            if (accept) begin
               case (vna_pkg::req_kind_type'(req_tuser))
                  vna_pkg::REQ_LOAD: begin
                     st_ctrl.pos_we    = 1'b1;
                     st_ctrl.pos_waddr = req_tdata[7:0];
                     st_ctrl.pos_wdata = req_tdata[55:8];
                     st_ctrl.sum_clr   = 1'b1;
                     st_ctrl.sum_caddr = req_tdata[7:0];
                  end
                  vna_pkg::REQ_TRI: begin
                     idx_in[0] = req_tdata[63:56];
                     idx_in[1] = req_tdata[71:64];
                     idx_in[2] = req_tdata[79:72];
                     is_tri_in = 1'b1;
                     cnt_in    = '0;
                     state_in  = vna_pkg::ST_FETCH;
                  end
                  vna_pkg::REQ_READ: begin
                     idx_in[0] = req_tdata[7:0];
                     is_tri_in = 1'b0;
                     cnt_in    = '0;
                     state_in  = vna_pkg::ST_SREAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Read the three positions, one per cycle
         vna_pkg::ST_FETCH: begin
            if (cnt_ff < 6'd3) begin
               st_ctrl.pos_re    = 1'b1;
               st_ctrl.pos_raddr = idx_ff[pick];
            end
            if (cnt_ff != '0) begin
               p_in[step[1:0]] = pos_rdata;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = vna_pkg::ST_EDGE;
            end
         end
         // Form the edges b - a and c - a from vertex a
         vna_pkg::ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = 17'(signed'(p_ff[1][16*i +: 16])) -
                          17'(signed'(p_ff[0][16*i +: 16]));
               e2_in[i] = 17'(signed'(p_ff[2][16*i +: 16])) -
                          17'(signed'(p_ff[0][16*i +: 16]));
            end
            cnt_in   = '0;
            state_in = vna_pkg::ST_CROSS;
         end
         // Six products, accumulated in the cycle after issue
         vna_pkg::ST_CROSS: begin
            case (cnt_ff[2:0])
               3'd0:    begin mul_a = ext17(e1_ff[1]); mul_b = ext17(e2_ff[2]); end
               3'd1:    begin mul_a = ext17(e1_ff[2]); mul_b = ext17(e2_ff[1]); end
               3'd2:    begin mul_a = ext17(e1_ff[2]); mul_b = ext17(e2_ff[0]); end
               3'd3:    begin mul_a = ext17(e1_ff[0]); mul_b = ext17(e2_ff[2]); end
               3'd4:    begin mul_a = ext17(e1_ff[0]); mul_b = ext17(e2_ff[1]); end
               3'd5:    begin mul_a = ext17(e1_ff[1]); mul_b = ext17(e2_ff[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            if (cnt_ff != '0) begin
               if (!step[0]) begin
                  c_in[step[2:1]] = prod[CW-1:0];
               end else begin
                  c_in[step[2:1]] = c_ff[step[2:1]] - prod[CW-1:0];
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd6) begin
               state_in = vna_pkg::ST_ABS;
            end
         end
         // Fetch the vertex sum
         vna_pkg::ST_SREAD: begin
            if (cnt_ff == '0) begin
               st_ctrl.sum_re    = 1'b1;
               st_ctrl.sum_raddr = idx_ff[0];
               cnt_in            = 6'd1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  c_in[i] = CW'(signed'(sum_rdata[24*i +: 24]));
               end
               state_in = vna_pkg::ST_ABS;
            end
         end
         // Split into sign and magnitude; drop a zero triangle normal, return a zero read sum as zero
         vna_pkg::ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = c_ff[i][CW-1];
               m_in[i]   = c_ff[i][CW-1] ? MW'(-c_ff[i]) : c_ff[i][MW-1:0];
            end
            if (c_ff[0] == '0 && c_ff[1] == '0 && c_ff[2] == '0) begin
               if (is_tri_ff) begin
                  state_in = vna_pkg::ST_IDLE;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     n_in[i] = '0;
                  end
                  zero_in  = 1'b1;
                  state_in = vna_pkg::ST_OUT;
               end
            end else begin
               zero_in  = 1'b0;
               state_in = vna_pkg::ST_SHIFT;
            end
         end
         // Scale so the largest magnitude lies in [2^29, 2^30)
         vna_pkg::ST_SHIFT: begin
            if (any_hi) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else if (all_lo) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
            end else begin
               cnt_in   = '0;
               state_in = vna_pkg::ST_SQ;
            end
         end
         // Sum of squares
         vna_pkg::ST_SQ: begin
            mul_a = {1'b0, m_ff[pick][29:0]};
            mul_b = {1'b0, m_ff[pick][29:0]};
            if (cnt_ff == 6'd1) begin
               s_in = SW'(prod);
            end else if (cnt_ff != '0) begin
               s_in = s_ff + SW'(prod);
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               x_in     = s_in;
               res_in   = '0;
               bit_in   = SW'(1) << 60;
               cnt_in   = '0;
               state_in = vna_pkg::ST_SQRT;
            end
         end
         // Integer square root, one result bit per cycle
         vna_pkg::ST_SQRT: begin
            if (x_ff >= t_sq) begin
               x_in   = x_ff - t_sq;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd30) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = vna_pkg::ST_DIV;
            end
         end
         // Rounded divide (m * 2^15 + L) / 2L, one quotient bit per cycle
         vna_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               rem_in = 33'(m_ff[comp_ff][29:0]) + 33'(len[30:15]);
               lo_in  = len[14:0];
               q_in   = '0;
            end else begin
               rem_in = (r2 >= div_d) ? (r2 - div_d) : r2;
               lo_in  = lo_ff << 1;
               q_in   = q_new;
               if (cnt_ff == 6'd15) begin
                  n_in[comp_ff] = neg_ff[comp_ff] ? -16'(signed'({1'b0, q_new}))
                                                  : 16'(signed'({1'b0, q_new}));
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  state_in = is_tri_ff ? vna_pkg::ST_ACC : vna_pkg::ST_OUT;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         // Read-modify-write the three vertex sums
         vna_pkg::ST_ACC: begin
            if (cnt_ff < 6'd3) begin
               st_ctrl.sum_re    = 1'b1;
               st_ctrl.sum_raddr = idx_ff[pick];
            end
            if (cnt_ff != '0) begin
               st_ctrl.sum_we    = 1'b1;
               st_ctrl.sum_waddr = idx_ff[step[1:0]];
               for (int i = 0; i < 3; i++) begin
                  sum_old = sum_rdata[24*i +: 24];
                  sum_new = sat_add(sum_old, n_ff[i]);
                  st_ctrl.sum_wdata[24*i +: 24] = sum_new;
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = vna_pkg::ST_IDLE;
            end
         end
         // Hand the result to the output register
         vna_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {n_ff[2], n_ff[1], n_ff[0]};
               rsp_zero_in  = zero_ff;
               state_in     = vna_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vna_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vna_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      is_tri_ff   <= is_tri_in;
      s_ff        <= s_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      q_ff        <= q_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
      for (int i = 0; i < 3; i++) begin
         idx_ff[i] <= idx_in[i];
         p_ff[i]   <= p_in[i];
         e1_ff[i]  <= e1_in[i];
         e2_ff[i]  <= e2_in[i];
         c_ff[i]   <= c_in[i];
         m_ff[i]   <= m_in[i];
         neg_ff[i] <= neg_in[i];
         n_ff[i]   <= n_in[i];
      end
   end

endmodule

>>> hw/rtl/vna_mult.sv
// Shared signed multiplier with a registered product.
// Depends on vna_pkg for operand widths.
module vna_mult (
   input  logic                                 clock,
   input  logic signed [vna_pkg::MUL_W-1:0]     mul_a,
   input  logic signed [vna_pkg::MUL_W-1:0]     mul_b,
   output logic signed [vna_pkg::PROD_W-1:0]    prod_ff
);

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

>>> hw/rtl/vna_store.sv
// Position memory and normal sum memory with per-vertex valid bits.
// Depends on vna_pkg for the access struct and widths.
module vna_store (
   input  logic                                clock,
   input  logic                                reset,
   input  vna_pkg::store_ctrl_type             ctrl,
   output logic [3*vna_pkg::POS_W-1:0]         pos_rdata,
   output logic [3*vna_pkg::SUM_W-1:0]         sum_rdata
);

   logic [3*vna_pkg::POS_W-1:0] pos_mem [vna_pkg::VERTEX_COUNT];
   logic [3*vna_pkg::SUM_W-1:0] sum_mem [vna_pkg::VERTEX_COUNT];
   logic [vna_pkg::VERTEX_COUNT-1:0] valid_ff;
   logic [3*vna_pkg::POS_W-1:0] pos_rd_ff;
   logic [3*vna_pkg::SUM_W-1:0] sum_rd_ff;
   logic                        sum_vld_ff;

   // Position memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.pos_we) begin
         pos_mem[ctrl.pos_waddr] <= ctrl.pos_wdata;
      end
      if (ctrl.pos_re) begin
         pos_rd_ff <= pos_mem[ctrl.pos_raddr];
      end
   end

   // Sum memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.sum_we) begin
         sum_mem[ctrl.sum_waddr] <= ctrl.sum_wdata;
      end
      if (ctrl.sum_re) begin
         sum_rd_ff <= sum_mem[ctrl.sum_raddr];
      end
   end

   // Valid bits: a sum entry that is not valid reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         sum_vld_ff <= 1'b0;
      end else begin
         if (ctrl.sum_clr) begin
            valid_ff[ctrl.sum_caddr] <= 1'b0;
         end
         if (ctrl.sum_we) begin
            valid_ff[ctrl.sum_waddr] <= 1'b1;
         end
         if (ctrl.sum_re) begin
            sum_vld_ff <= valid_ff[ctrl.sum_raddr];
         end
      end
   end

   assign pos_rdata = pos_rd_ff;
   assign sum_rdata = sum_vld_ff ? sum_rd_ff : '0;

endmodule
